// ===== rtl/aes128_pkg.sv =====
// Shared constants, S-box table and GF(2^8) helpers for the AES-128 encrypt block.
// No dependencies; used by every file under rtl.
package aes128_pkg;

   localparam int BLOCK_W    = 128;
   localparam int HALF_W     = 64;
   localparam int WORD_W     = 32;
   localparam int ROUNDS     = 10;
   localparam int ROUND_W    = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_HIGH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LOW  = 2'd1;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] GF_POLY    = 8'h1b;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [7:0]         byte_type;

   // control from the sequencer to the round unit and the key step
   typedef struct packed {
      logic last;
      logic [7:0] rcon;
   } round_ctrl_type;

   localparam byte_type SBOX_TABLE [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic byte_type sbox(input byte_type a);
      return SBOX_TABLE[a];
   endfunction

   function automatic byte_type xtime8(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

endpackage

// ===== rtl/aes128_key_step.sv =====
// One step of the AES-128 key schedule: previous round key to next round key.
// Depends on aes128_pkg (sbox, widths).
module aes128_key_step (
   input  aes128_pkg::block_type rk_prev,
   input  logic [7:0]            rcon,
   output aes128_pkg::block_type rk_next
);

   logic [aes128_pkg::WORD_W-1:0] w0, w1, w2, w3, t, n0, n1, n2, n3;

   always_comb begin
      w0 = rk_prev[127:96];
      w1 = rk_prev[95:64];
      w2 = rk_prev[63:32];
      w3 = rk_prev[31:0];
      // RotWord then SubWord, rcon into the top byte
      t = {aes128_pkg::sbox(w3[23:16]) ^ rcon,
           aes128_pkg::sbox(w3[15:8]),
           aes128_pkg::sbox(w3[7:0]),
           aes128_pkg::sbox(w3[31:24])};
      n0 = w0 ^ t;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
      rk_next = {n0, n1, n2, n3};
   end

endmodule

// ===== rtl/aes128_round.sv =====
// Shared AES round datapath: SubBytes, ShiftRows, MixColumns (skipped on the
// last round) and AddRoundKey. Depends on aes128_pkg.
module aes128_round (
   input  aes128_pkg::block_type      state_cur,
   input  aes128_pkg::block_type      rk_cur,
   input  aes128_pkg::round_ctrl_type ctrl,
   output aes128_pkg::block_type      state_next
);

   aes128_pkg::byte_type st [16];
   aes128_pkg::byte_type sb [16];
   aes128_pkg::byte_type mx [16];

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         st[k] = state_cur[127-8*k -: 8];
      end
      // byte k sits at row k%4, column k/4
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sb[4*c+r] = aes128_pkg::sbox(st[4*((c+r)%4)+r]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         mx[4*c]   = aes128_pkg::xtime8(sb[4*c]) ^ aes128_pkg::xtime8(sb[4*c+1])
                     ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
         mx[4*c+1] = sb[4*c] ^ aes128_pkg::xtime8(sb[4*c+1])
                     ^ aes128_pkg::xtime8(sb[4*c+2]) ^ sb[4*c+2] ^ sb[4*c+3];
         mx[4*c+2] = sb[4*c] ^ sb[4*c+1] ^ aes128_pkg::xtime8(sb[4*c+2])
                     ^ aes128_pkg::xtime8(sb[4*c+3]) ^ sb[4*c+3];
         mx[4*c+3] = aes128_pkg::xtime8(sb[4*c]) ^ sb[4*c] ^ sb[4*c+1]
                     ^ sb[4*c+2] ^ aes128_pkg::xtime8(sb[4*c+3]);
      end
      for (int k = 0; k < 16; k++) begin
         state_next[127-8*k -: 8] = (ctrl.last ? sb[k] : mx[k]) ^ rk_cur[127-8*k -: 8];
      end
   end

endmodule

// ===== rtl/aes128_block_encrypt_top.sv =====
// AES-128 block encrypt top level: key registers, round sequencer, output register.
// Depends on aes128_pkg, aes128_key_step and aes128_round.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_plain_high, req_plain_low
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_cipher_high, rsp_cipher_low
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// A block goes through the key addition at accept, then ten passes through
// the one shared round unit, with the round key built alongside one schedule
// step per cycle. req_stall is high while a block is in flight.
// Reset is synchronous and clears control and the key registers (all-zero key).
// A stalled result holds in the output register; a block finishing behind it
// waits in its last round until the register frees.
module aes128_block_encrypt_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [aes128_pkg::HALF_W-1:0]         req_plain_high,
   input  logic [aes128_pkg::HALF_W-1:0]         req_plain_low,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [aes128_pkg::HALF_W-1:0]         rsp_cipher_high,
   output logic [aes128_pkg::HALF_W-1:0]         rsp_cipher_low,
   input  logic                                  csr_we,
   input  logic [aes128_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [aes128_pkg::HALF_W-1:0]         csr_wdata
);

   typedef enum logic {IDLE, BUSY} state_type;

   state_type                         state_ff, state_in;
   logic [aes128_pkg::ROUND_W-1:0]    round_ff, round_in;
   logic [7:0]                        rcon_ff, rcon_in;
   aes128_pkg::block_type             data_ff, data_in;
   aes128_pkg::block_type             rk_ff, rk_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   aes128_pkg::block_type             rsp_data_ff, rsp_data_in;
   logic [aes128_pkg::HALF_W-1:0]     key_high_ff, key_low_ff;

   aes128_pkg::block_type             rk_next, round_out, key_full;
   aes128_pkg::round_ctrl_type        ctrl;
   logic                              req_take, slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == aes128_pkg::REG_KEY_HIGH) begin
            key_high_ff <= csr_wdata;
         end else if (csr_index == aes128_pkg::REG_KEY_LOW) begin
            key_low_ff <= csr_wdata;
         end
      end
   end

   assign key_full  = {key_high_ff, key_low_ff};
   assign req_stall = (state_ff == BUSY);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign ctrl.last = (round_ff == aes128_pkg::ROUND_W'(aes128_pkg::ROUNDS));
   assign ctrl.rcon = rcon_ff;

   aes128_key_step u_key_step (
      .rk_prev (rk_ff),
      .rcon    (ctrl.rcon),
      .rk_next (rk_next)
   );

   aes128_round u_round (
      .state_cur  (data_ff),
      .rk_cur     (rk_next),
      .ctrl       (ctrl),
      .state_next (round_out)
   );

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      rcon_in      = rcon_ff;
      data_in      = data_ff;
      rk_in        = rk_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_take) begin
               state_in = BUSY;
               round_in = aes128_pkg::ROUND_W'(1);
               rcon_in  = aes128_pkg::RCON_FIRST;
               data_in  = {req_plain_high, req_plain_low} ^ key_full;
               rk_in    = key_full;
            end
         end
         BUSY: begin
            if (!ctrl.last) begin
               round_in = round_ff + aes128_pkg::ROUND_W'(1);
               rcon_in  = aes128_pkg::xtime8(rcon_ff);
               data_in  = round_out;
               rk_in    = rk_next;
            end else if (slot_free) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = round_out;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         round_ff     <= '0;
         rcon_ff      <= aes128_pkg::RCON_FIRST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         round_ff     <= round_in;
         rcon_ff      <= rcon_in;
         data_ff      <= data_in;
         rk_ff        <= rk_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_high = rsp_data_ff[127:64];
   assign rsp_cipher_low  = rsp_data_ff[63:0];

endmodule

// ===== rtl/aes128_checker.sv =====
// Port-level checks for the AES-128 encrypt top level, plus its bind.
// Depends on aes128_pkg and aes128_block_encrypt_top.
module aes128_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [aes128_pkg::HALF_W-1:0]      req_plain_high,
   input logic [aes128_pkg::HALF_W-1:0]      req_plain_low,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [aes128_pkg::HALF_W-1:0]      rsp_cipher_high,
   input logic [aes128_pkg::HALF_W-1:0]      rsp_cipher_low,
   input logic                               csr_we,
   input logic [aes128_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [aes128_pkg::HALF_W-1:0]      csr_wdata
);

   // no result right out of reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // an accepted transaction blocks the input channel on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled while a block is in flight");

   // a rising rsp_valid must trace back to an accepted transaction, delayed by the key addition and the ten rounds
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 11))
      else $error("result without a transaction eleven cycles earlier");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_cipher_high)
                                    && $stable(rsp_cipher_low)))
      else $error("stalled result changed");

endmodule

bind aes128_block_encrypt_top aes128_checker u_aes128_checker (.*);
